>>> design/pcmv_pkg.sv
// shared constants and types for the colour mode vote block
package pcmv_pkg;
  localparam int MaxSamplesDef = 512;
  localparam int QuantBitsDef  = 6;
  localparam int CountW        = 10;
  localparam int ChanW         = 8;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic             last;
  } sample_t;
endpackage

>>> design/pcmv_front.sv
// front end: accepts sample words into a two-entry queue
module pcmv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pcmv_pkg::sample_t in_word_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output pcmv_pkg::sample_t q_word_o
);
  import pcmv_pkg::*;

  sample_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_word_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

>>> design/pcmv_back.sv
// back end: histogram read-modify-write sequencer, result register and clear replay
module pcmv_back #(
  parameter int MaxSamples = pcmv_pkg::MaxSamplesDef,
  parameter int QuantBits  = pcmv_pkg::QuantBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  pcmv_pkg::sample_t             q_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pcmv_pkg::ChanW-1:0]    bg_blue_o,
  output logic [pcmv_pkg::ChanW-1:0]    bg_green_o,
  output logic [pcmv_pkg::ChanW-1:0]    bg_red_o,
  output logic [pcmv_pkg::CountW-1:0]   vote_count_o
);
  import pcmv_pkg::*;

  localparam int Qb    = QuantBits;
  localparam int IdxW  = 3 * Qb;
  localparam int Depth = 1 << IdxW;
  localparam int QSh   = ChanW - Qb;
  localparam int SAW   = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int SCW   = $clog2(MaxSamples + 1);
  localparam logic [ChanW-1:0] Half = ChanW'((1 << QSh) >> 1);
  localparam logic [SCW-1:0]   MaxCnt = SCW'(MaxSamples);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRd   = 4'd1;
  localparam logic [3:0] StWr   = 4'd2;
  localparam logic [3:0] StOut  = 4'd3;
  localparam logic [3:0] StCLd  = 4'd4;
  localparam logic [3:0] StCFet = 4'd5;
  localparam logic [3:0] StCRd  = 4'd6;
  localparam logic [3:0] StCWr  = 4'd7;
  localparam logic [3:0] StClr  = 4'd8;

  logic [CountW-1:0] hist_q [Depth];
  logic [IdxW-1:0]   store_q [MaxSamples];

  logic [3:0]        st_q;
  logic [IdxW-1:0]   cur_q;
  logic [1:0]        db_q, dg_q, dr_q;
  logic              last_q;
  logic [SCW-1:0]    scnt_q, ci_q;
  logic [CountW-1:0] best_q, rd_q;
  logic [IdxW-1:0]   bbk_q, addr_q, st_rd_q;
  logic              ov_q;
  logic [ChanW-1:0]  ob_q, og_q, or_q;
  logic [CountW-1:0] oc_q;

  logic [Qb-1:0]   cb, cg, cr, nb, ng, nr;
  logic            okb, okg, okr, inr, lastoff;
  logic [Qb:0]     sb, sg, sr;
  logic [CountW-1:0] inc, dec;
  logic            can_out;

  assign cb = cur_q[IdxW-1 -: Qb];
  assign cg = cur_q[2*Qb-1 -: Qb];
  assign cr = cur_q[Qb-1:0];
  // neighbour coordinate, offset code 0..2 means -1..+1
  assign sb = {1'b0, cb} + {{(Qb-1){1'b0}}, db_q} - (Qb+1)'(1);
  assign sg = {1'b0, cg} + {{(Qb-1){1'b0}}, dg_q} - (Qb+1)'(1);
  assign sr = {1'b0, cr} + {{(Qb-1){1'b0}}, dr_q} - (Qb+1)'(1);
  assign okb = !sb[Qb];
  assign okg = !sg[Qb];
  assign okr = !sr[Qb];
  assign nb = sb[Qb-1:0];
  assign ng = sg[Qb-1:0];
  assign nr = sr[Qb-1:0];
  assign inr = okb && okg && okr;
  assign lastoff = (db_q == 2'd2) && (dg_q == 2'd2) && (dr_q == 2'd2);
  assign inc = (rd_q == CountMax) ? rd_q : rd_q + CountW'(1);
  assign dec = (rd_q == '0) ? rd_q : rd_q - CountW'(1);
  assign can_out = !ov_q || !out_stall_i;

  assign q_pop_o      = (st_q == StIdle) && q_valid_i;
  assign out_valid_o  = ov_q;
  assign bg_blue_o    = ob_q;
  assign bg_green_o   = og_q;
  assign bg_red_o     = or_q;
  assign vote_count_o = oc_q;

  function automatic logic [ChanW-1:0] centre(input logic [Qb-1:0] q);
    return ChanW'({q, {QSh{1'b0}}}) + Half;
  endfunction

  // histogram port: one read or one write each cycle
  always_ff @(posedge clk_i) begin
    if (st_q == StRd || st_q == StCRd) rd_q <= hist_q[{nb, ng, nr}];
    if (st_q == StWr) hist_q[addr_q] <= inc;
    if (st_q == StCWr) hist_q[addr_q] <= dec;
    if (st_q == StClr) hist_q[addr_q] <= '0;
    if (q_pop_o && scnt_q < MaxCnt)
      store_q[scnt_q[SAW-1:0]] <= {q_word_i.blue[ChanW-1 -: Qb],
                                   q_word_i.green[ChanW-1 -: Qb],
                                   q_word_i.red[ChanW-1 -: Qb]};
    if (st_q == StCLd) st_rd_q <= store_q[ci_q[SAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; cur_q <= '0; db_q <= '0; dg_q <= '0; dr_q <= '0;
      last_q <= 1'b0; scnt_q <= '0; ci_q <= '0; best_q <= '0; bbk_q <= '0;
      addr_q <= '0; ov_q <= 1'b0;
      ob_q <= '0; og_q <= '0; or_q <= '0; oc_q <= '0;
    end else begin
      if (ov_q && !out_stall_i && !(st_q == StOut && can_out)) ov_q <= 1'b0;
      unique case (st_q)
        StClr: begin
          // zero every histogram entry once after reset
          addr_q <= addr_q + IdxW'(1);
          if (addr_q == '1) st_q <= StIdle;
        end
        StIdle: begin
          if (q_valid_i) begin
            last_q <= q_word_i.last;
            cur_q <= {q_word_i.blue[ChanW-1 -: Qb], q_word_i.green[ChanW-1 -: Qb],
                      q_word_i.red[ChanW-1 -: Qb]};
            db_q <= '0; dg_q <= '0; dr_q <= '0;
            if (scnt_q < MaxCnt) begin
              scnt_q <= scnt_q + SCW'(1);
              st_q <= StRd;
            end else if (q_word_i.last) begin
              st_q <= StOut;
            end
          end
        end
        StRd: begin
          // walk offsets, skipping those out of range; red innermost
          addr_q <= {nb, ng, nr};
          if (inr) st_q <= StWr;
          else begin
            if (dr_q != 2'd2) dr_q <= dr_q + 2'd1;
            else begin
              dr_q <= '0;
              if (dg_q != 2'd2) dg_q <= dg_q + 2'd1;
              else begin dg_q <= '0; db_q <= db_q + 2'd1; end
            end
            if (lastoff) st_q <= last_q ? StOut : StIdle;
          end
        end
        StWr: begin
          if (inc > best_q) begin best_q <= inc; bbk_q <= addr_q; end
          if (dr_q != 2'd2) dr_q <= dr_q + 2'd1;
          else begin
            dr_q <= '0;
            if (dg_q != 2'd2) dg_q <= dg_q + 2'd1;
            else begin dg_q <= '0; db_q <= db_q + 2'd1; end
          end
          st_q <= lastoff ? (last_q ? StOut : StIdle) : StRd;
        end
        StOut: begin
          if (can_out) begin
            ov_q <= 1'b1;
            ob_q <= centre(bbk_q[IdxW-1 -: Qb]);
            og_q <= centre(bbk_q[2*Qb-1 -: Qb]);
            or_q <= centre(bbk_q[Qb-1:0]);
            oc_q <= best_q;
            best_q <= '0; bbk_q <= '0; ci_q <= '0;
            st_q <= (scnt_q == '0) ? StIdle : StCLd;
          end
        end
        StCLd: st_q <= StCFet;
        StCFet: begin
          cur_q <= st_rd_q;
          db_q <= '0; dg_q <= '0; dr_q <= '0;
          ci_q <= ci_q + SCW'(1);
          st_q <= StCRd;
        end
        StCRd: begin
          addr_q <= {nb, ng, nr};
          if (inr) st_q <= StCWr;
          else begin
            if (dr_q != 2'd2) dr_q <= dr_q + 2'd1;
            else begin
              dr_q <= '0;
              if (dg_q != 2'd2) dg_q <= dg_q + 2'd1;
              else begin dg_q <= '0; db_q <= db_q + 2'd1; end
            end
            if (lastoff) begin
              if (ci_q == scnt_q) begin scnt_q <= '0; st_q <= StIdle; end
              else st_q <= StCLd;
            end
          end
        end
        StCWr: begin
          if (dr_q != 2'd2) dr_q <= dr_q + 2'd1;
          else begin
            dr_q <= '0;
            if (dg_q != 2'd2) dg_q <= dg_q + 2'd1;
            else begin dg_q <= '0; db_q <= db_q + 2'd1; end
          end
          if (lastoff) begin
            if (ci_q == scnt_q) begin scnt_q <= '0; st_q <= StIdle; end
            else st_q <= StCLd;
          end else st_q <= StCRd;
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

>>> design/pixel_color_mode_vote_top.sv
// top level of the temporal colour mode vote block
// a word is voted with a read and a write per in-range bucket on the single histogram port,
//   while each skipped offset only advances the walk; past the store depth the back end takes
//   one word per cycle while it is idle; the clear replay after a result reads each stored word
//   back and takes back its votes, and later words wait in the queue
// reset: registers clear, then the clear state zeroes one histogram entry per cycle (262144 at 6 bits)
module pixel_color_mode_vote_top #(
  parameter int MaxSamples = pcmv_pkg::MaxSamplesDef,
  parameter int QuantBits  = pcmv_pkg::QuantBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pcmv_pkg::ChanW-1:0]  blue_i,
  input  logic [pcmv_pkg::ChanW-1:0]  green_i,
  input  logic [pcmv_pkg::ChanW-1:0]  red_i,
  input  logic                        last_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pcmv_pkg::ChanW-1:0]  bg_blue_o,
  output logic [pcmv_pkg::ChanW-1:0]  bg_green_o,
  output logic [pcmv_pkg::ChanW-1:0]  bg_red_o,
  output logic [pcmv_pkg::CountW-1:0] vote_count_o
);
  import pcmv_pkg::*;

  sample_t in_word, q_word;
  logic    q_valid, q_pop;

  // input word packing
  assign in_word = '{blue: blue_i, green: green_i, red: red_i, last: last_sample_i};

  pcmv_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .in_word_i(in_word), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_word_o(q_word)
  );

  // vote engine and result register
  pcmv_back #(.MaxSamples(MaxSamples), .QuantBits(QuantBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_word_i(q_word),
    .out_valid_o, .out_stall_i, .bg_blue_o, .bg_green_o, .bg_red_o, .vote_count_o
  );
endmodule

>>> sim/pixel_color_mode_vote_top_tb.sv
// testbench for the temporal colour mode vote block, self-checking against its own vote model and hand-typed results
module pixel_color_mode_vote_top_tb;
  import pcmv_pkg::*;

  localparam int QBits     = QuantBitsDef;
  localparam int QShift    = ChanW - QBits;
  localparam int QLevels   = 1 << QBits;
  localparam int HistDepth = 1 << (3 * QBits);
  localparam int HalfBkt   = (1 << QShift) >> 1;
  localparam int HoldOff   = 400;

  // one result word: winning bucket centre and its vote count
  typedef struct {
    bit [ChanW-1:0]  b;
    bit [ChanW-1:0]  g;
    bit [ChanW-1:0]  r;
    bit [CountW-1:0] n;
  } mode_t;

  // one row of the directed table; known marks a result typed in by hand
  typedef struct {
    bit [ChanW-1:0] b;
    bit [ChanW-1:0] g;
    bit [ChanW-1:0] r;
    bit             last;
    bit             known;
    mode_t          want;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [ChanW-1:0]  blue_i;
  logic [ChanW-1:0]  green_i;
  logic [ChanW-1:0]  red_i;
  logic              last_sample_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ChanW-1:0]  bg_blue_o;
  logic [ChanW-1:0]  bg_green_o;
  logic [ChanW-1:0]  bg_red_o;
  logic [CountW-1:0] vote_count_o;

  pixel_color_mode_vote_top dut (.*);

  // vote model state
  bit [CountW-1:0]  vote_hist [HistDepth];
  bit [3*QBits-1:0] kept_px [MaxSamplesDef];
  int unsigned      n_kept;
  bit [CountW-1:0]  top_votes;
  bit [3*QBits-1:0] top_bucket;

  mode_t mode_q [$];
  bit    failed;
  int    send_idle_pct;
  int    stall_pct;
  int    hold_left;

  // adds or takes back the votes of one quantized sample, blue outermost
  function automatic void tally(bit [3*QBits-1:0] px, bit add);
    int qb, qg, qr, nb, ng, nr;
    bit [3*QBits-1:0] idx;
    qb = px[3*QBits-1:2*QBits];
    qg = px[2*QBits-1:QBits];
    qr = px[QBits-1:0];
    for (int db = -1; db <= 1; db++)
      for (int dg = -1; dg <= 1; dg++)
        for (int dr = -1; dr <= 1; dr++) begin
          nb = qb + db;
          ng = qg + dg;
          nr = qr + dr;
          if (nb < 0 || nb >= QLevels || ng < 0 || ng >= QLevels ||
              nr < 0 || nr >= QLevels) continue;
          idx = {nb[QBits-1:0], ng[QBits-1:0], nr[QBits-1:0]};
          if (add) begin
            if (vote_hist[idx] != CountMax) vote_hist[idx]++;
            // only a strict rise takes the lead, so the first one wins a tie
            if (vote_hist[idx] > top_votes) begin
              top_votes  = vote_hist[idx];
              top_bucket = idx;
            end
          end else if (vote_hist[idx] != 0) begin
            vote_hist[idx]--;
          end
        end
  endfunction

  function automatic bit [ChanW-1:0] centre(bit [QBits-1:0] q);
    return (ChanW'(q) << QShift) + ChanW'(HalfBkt);
  endfunction

  // takes one accepted word into the model; true when it yields a result
  function automatic bit vote_sample(bit [ChanW-1:0] b, bit [ChanW-1:0] g,
                                     bit [ChanW-1:0] r, bit last, output mode_t res);
    bit [3*QBits-1:0] px;
    px = {b[ChanW-1 -: QBits], g[ChanW-1 -: QBits], r[ChanW-1 -: QBits]};
    // past the store depth a sample casts no votes
    if (n_kept < MaxSamplesDef) begin
      kept_px[n_kept] = px;
      n_kept++;
      tally(px, 1'b1);
    end
    if (!last) return 1'b0;
    res.b = centre(top_bucket[3*QBits-1:2*QBits]);
    res.g = centre(top_bucket[2*QBits-1:QBits]);
    res.r = centre(top_bucket[QBits-1:0]);
    res.n = top_votes;
    for (int i = 0; i < n_kept; i++) tally(kept_px[i], 1'b0);
    n_kept     = 0;
    top_votes  = '0;
    top_bucket = '0;
    return 1'b1;
  endfunction

  // offer one word, optionally with a hand-typed result in place of the model's
  task automatic send_word(bit [ChanW-1:0] b, bit [ChanW-1:0] g, bit [ChanW-1:0] r,
                           bit last, bit known = 1'b0, mode_t want = '{default: 0});
    mode_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    blue_i        <= b;
    green_i       <= g;
    red_i         <= r;
    last_sample_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (vote_sample(b, g, r, last, res)) mode_q.insert(mode_q.size(), known ? want : res);
    @(negedge clk_i);
  endtask

  function automatic bit [ChanW-1:0] near(int base);
    int v;
    v = base + $urandom_range(0, 8) - 4;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : ChanW'(v);
  endfunction

  // one pixel position: mostly clustered around a colour, sometimes plain noise
  task automatic send_pixel(int len);
    int bb, gb, rb;
    bit noisy;
    bb    = $urandom_range(255);
    gb    = $urandom_range(255);
    rb    = $urandom_range(255);
    noisy = ($urandom_range(9) < 2);
    for (int i = 0; i < len; i++) begin
      if (noisy || $urandom_range(4) == 0)
        send_word(ChanW'($urandom), ChanW'($urandom), ChanW'($urandom), i == len - 1);
      else
        send_word(near(bb), near(gb), near(rb), i == len - 1);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (mode_q.size() == 0);
    @(negedge clk_i);
  endtask

  row_t rows [] = '{
    // single samples: corner, far corner and middle
    '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1, '{8'd2, 8'd2, 8'd2, 10'd1}},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, '{8'd250, 8'd250, 8'd250, 10'd1}},
    '{8'd128, 8'd64, 8'd32, 1'b1, 1'b1, '{8'd126, 8'd62, 8'd30, 10'd1}},
    // three in one corner bucket
    '{8'd1, 8'd2, 8'd3, 1'b0, 1'b0, '{default: 0}},
    '{8'd1, 8'd2, 8'd3, 1'b0, 1'b0, '{default: 0}},
    '{8'd1, 8'd2, 8'd3, 1'b1, 1'b1, '{8'd2, 8'd2, 8'd2, 10'd3}},
    // overlapping neighbourhoods
    '{8'd10, 8'd10, 8'd10, 1'b0, 1'b0, '{default: 0}},
    '{8'd14, 8'd11, 8'd9, 1'b0, 1'b0, '{default: 0}},
    '{8'd200, 8'd100, 8'd50, 1'b1, 1'b0, '{default: 0}},
    '{8'd3, 8'd255, 8'd0, 1'b0, 1'b0, '{default: 0}},
    '{8'd255, 8'd0, 8'd255, 1'b1, 1'b0, '{default: 0}},
    // mixed edges
    '{8'd255, 8'd0, 8'd0, 1'b0, 1'b0, '{default: 0}},
    '{8'd0, 8'd255, 8'd255, 1'b0, 1'b0, '{default: 0}},
    '{8'd0, 8'd0, 8'd255, 1'b0, 1'b0, '{default: 0}},
    '{8'd255, 8'd255, 8'd0, 1'b1, 1'b0, '{default: 0}},
    '{8'd127, 8'd128, 8'd131, 1'b0, 1'b0, '{default: 0}},
    '{8'd124, 8'd132, 8'd127, 1'b1, 1'b0, '{default: 0}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall, or a long hold-off when one is asked for
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // result checker: every taken word against the oldest expectation
  always @(posedge clk_i) begin
    mode_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mode_q.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d n=%0d", $time,
                 bg_blue_o, bg_green_o, bg_red_o, vote_count_o);
        failed = 1'b1;
      end else begin
        want = mode_q.pop_front();
        if (bg_blue_o !== want.b) begin
          $display("%0t: bg_blue expected %0d got %0d", $time, want.b, bg_blue_o);
          failed = 1'b1;
        end
        if (bg_green_o !== want.g) begin
          $display("%0t: bg_green expected %0d got %0d", $time, want.g, bg_green_o);
          failed = 1'b1;
        end
        if (bg_red_o !== want.r) begin
          $display("%0t: bg_red expected %0d got %0d", $time, want.r, bg_red_o);
          failed = 1'b1;
        end
        if (vote_count_o !== want.n) begin
          $display("%0t: vote_count expected %0d got %0d", $time, want.n, vote_count_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int bb, gb, rb;
    failed        = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    n_kept        = 0;
    top_votes     = '0;
    top_bucket    = '0;
    foreach (vote_hist[i]) vote_hist[i] = '0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    blue_i        = '0;
    green_i       = '0;
    red_i         = '0;
    last_sample_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i])
      send_word(rows[i].b, rows[i].g, rows[i].r, rows[i].last, rows[i].known, rows[i].want);
    // sender waits for every result before going on
    drain();

    // phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 68 : (ph == 3) ? 10 : 0;
      stall_pct     = (ph == 2) ? 68 : (ph == 3) ? 10 : 0;
      if (ph == 2) hold_left = HoldOff;
      for (int p = 0; p < 80; p++) begin
        // long hold-off while words keep coming so the input backs up
        if (ph == 0 && p == 20) hold_left = HoldOff;
        send_pixel($urandom_range(1, 6));
      end
      drain();
    end

    // too many samples: one colour past the store depth, count stops at the store depth
    send_idle_pct = 0;
    stall_pct     = 10;
    bb = $urandom_range(255);
    gb = $urandom_range(255);
    rb = $urandom_range(255);
    for (int i = 0; i < MaxSamplesDef + 8; i++)
      send_word(ChanW'(bb), ChanW'(gb), ChanW'(rb), i == MaxSamplesDef + 7);
    send_pixel(3);
    drain();

    repeat (100) @(posedge clk_i);
    if (!failed) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
